/* rtl/slid_pkg.sv */
// Package for the sorted insert/delete table: transfer payload types,
// status codes, sequencer states and the control word shared by the cells.
// No dependencies.
package slid_pkg;

  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DELETED  = 3'd1,
    ST_NOMATCH  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_APPLY
  } seq_state_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  typedef struct packed {
    action_e                   action;
    logic signed [ValueW-1:0]  operand_value;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [CountW-1:0]   entry_count;
  } out_item_t;

  // Phase strobes broadcast to every cell.
  typedef struct packed {
    logic compare;
    logic ins_apply;
    logic del_apply;
  } cell_ctrl_t;

endpackage

/* rtl/sorted_list_insert_delete.sv */
// Top level of the sorted insert/delete table: sequencer, entry count,
// result register and a row of slid_cell instances. Depends on slid_pkg.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+--------------------------
//   in      | sink      | in_valid_i/in_ready_o | slid_pkg::in_item_t
//   out     | source    | out_valid_o/out_ready_i | slid_pkg::out_item_t
//
// Each transfer in passes through these phases before the next is taken:
//   the accept edge latches the operation, the compare phase has every cell
//   compare its entry with the operand in parallel, and the apply phase loads
//   the result register and shifts the row one place if the table changes.
// Reset clears the sequencer, the entry count and the result valid flag;
//   the cell contents are left unwritten and are never read before a write.
// A stalled output holds the sequencer in the apply phase until the pending
//   result is taken; the cell flags stay put meanwhile.
module sorted_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  slid_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output slid_pkg::out_item_t  out_data_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  slid_pkg::seq_state_e state_q, state_d;
  slid_pkg::in_item_t   op_q, op_d;
  logic [CntW-1:0]      count_q, count_d;
  slid_pkg::out_item_t  out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  slid_pkg::cell_ctrl_t ctrl;
  logic                 apply_fire;
  logic                 found;
  logic                 full;
  logic                 empty;
  logic                 is_insert;

  logic signed [slid_pkg::ValueW-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_le;
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_match;

  assign full      = (count_q >= CntW'(CAPACITY));
  assign empty     = (count_q == '0);
  assign found     = |cell_match;
  assign is_insert = (op_q.action == slid_pkg::ACT_INSERT);

  // Next state: idle until a transfer in, then compare, then apply once the
  // result register is free.
  always_comb begin
    state_d = state_q;
    case (state_q)
      slid_pkg::S_IDLE: begin
        if (in_valid_i) state_d = slid_pkg::S_COMPARE;
      end
      slid_pkg::S_COMPARE: begin
        state_d = slid_pkg::S_APPLY;
      end
      slid_pkg::S_APPLY: begin
        if (apply_fire) state_d = slid_pkg::S_IDLE;
      end
      default: begin
        state_d = slid_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o     = 1'b0;
    apply_fire     = 1'b0;
    ctrl.compare   = 1'b0;
    ctrl.ins_apply = 1'b0;
    ctrl.del_apply = 1'b0;
    case (state_q)
      slid_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
      end
      slid_pkg::S_COMPARE: begin
        ctrl.compare = 1'b1;
      end
      slid_pkg::S_APPLY: begin
        apply_fire     = !out_valid_q || out_ready_i;
        // Shift only when the operation actually changes the table.
        ctrl.ins_apply = apply_fire && is_insert && !full;
        ctrl.del_apply = apply_fire && !is_insert && found;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Latch the operation, track the count and build the result.
  always_comb begin
    op_d        = op_q;
    count_d     = count_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (in_valid_i && in_ready_o) begin
      op_d = in_data_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (apply_fire) begin
      if (is_insert) begin
        if (full) begin
          out_d.status = slid_pkg::ST_FULL;
        end else begin
          out_d.status = slid_pkg::ST_INSERTED;
          count_d      = count_q + CntW'(1);
        end
      end else if (empty) begin
        out_d.status = slid_pkg::ST_EMPTY;
      end else if (found) begin
        out_d.status = slid_pkg::ST_DELETED;
        count_d      = count_q - CntW'(1);
      end else begin
        out_d.status = slid_pkg::ST_NOMATCH;
      end
      out_d.entry_count = slid_pkg::CountW'(count_d);
      out_valid_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slid_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    out_q <= out_d;
  end

  // Row of cells: each sees its left neighbour for inserts and its right
  // neighbour for deletes; the ends are tied off, the head as if an entry
  // below every operand stood to its left.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);

    logic signed [slid_pkg::ValueW-1:0] data_left;
    logic signed [slid_pkg::ValueW-1:0] data_right;
    logic                               le_left;
    logic                               lt_left;

    if (i == 0) begin : g_head
      assign data_left = cell_data[i];
      assign le_left   = 1'b1;
      assign lt_left   = 1'b1;
    end else begin : g_body
      assign data_left = cell_data[i-1];
      assign le_left   = cell_le[i-1];
      assign lt_left   = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign data_right = cell_data[i];
    end else begin : g_inner
      assign data_right = cell_data[i+1];
    end

    slid_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .occupied_i   (Idx < count_q),
      .operand_i    (op_q.operand_value),
      .data_left_i  (data_left),
      .data_right_i (data_right),
      .le_left_i    (le_left),
      .lt_left_i    (lt_left),
      .data_o       (cell_data[i]),
      .le_o         (cell_le[i]),
      .lt_o         (cell_lt[i]),
      .match_o      (cell_match[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/slid_cell.sv */
// One cell of the sorted table: holds a single entry plus its compare flags.
// Depends on slid_pkg.
module slid_cell (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  slid_pkg::cell_ctrl_t                   ctrl_i,
  input  logic                                   occupied_i,
  input  logic signed [slid_pkg::ValueW-1:0]     operand_i,
  input  logic signed [slid_pkg::ValueW-1:0]     data_left_i,
  input  logic signed [slid_pkg::ValueW-1:0]     data_right_i,
  input  logic                                   le_left_i,
  input  logic                                   lt_left_i,
  output logic signed [slid_pkg::ValueW-1:0]     data_o,
  output logic                                   le_o,
  output logic                                   lt_o,
  output logic                                   match_o
);

  logic signed [slid_pkg::ValueW-1:0] data_q, data_d;
  logic le_q, le_d;
  logic lt_q, lt_d;
  logic eq_q, eq_d;

  // Capture flags during the compare phase, hold them otherwise.
  always_comb begin
    le_d = le_q;
    lt_d = lt_q;
    eq_d = eq_q;
    if (ctrl_i.compare) begin
      le_d = occupied_i && (data_q <= operand_i);
      lt_d = occupied_i && (data_q < operand_i);
      eq_d = occupied_i && (data_q == operand_i);
    end
  end

  // Insert: open a gap at the first entry above the operand.
  // Delete: close the gap from the first entry not below the key.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins_apply && !le_q) begin
      data_d = le_left_i ? operand_i : data_left_i;
    end else if (ctrl_i.del_apply && !lt_q) begin
      data_d = data_right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q <= 1'b0;
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      le_q <= le_d;
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Match only at the first entry not below the key.
  assign data_o  = data_q;
  assign le_o    = le_q;
  assign lt_o    = lt_q;
  assign match_o = eq_q && lt_left_i;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sorted_list_insert_delete: drives insert and delete transfers,
// predicts status and entry count from its own copy of the sorted table.
// Depends on slid_pkg and the sorted_list_insert_delete RTL.
module testbench;

  localparam int unsigned Capacity      = 16;
  localparam int unsigned RandomItems   = 700;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned WatchdogLimit = 2000;

  // Predicts every result from a private copy of the table, kept sorted ascending,
  // and holds the predictions until the block returns them in order.
  class sorted_table_board;
    logic signed [slid_pkg::ValueW-1:0] stored_q[$];
    slid_pkg::out_item_t                expected_q[$];
    int unsigned                        fails;

    function int unsigned count();
      return stored_q.size();
    endfunction

    function logic signed [slid_pkg::ValueW-1:0] entry_at(int unsigned idx);
      return stored_q[idx];
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted operation to the table and queue its result.
    function void note_input(slid_pkg::in_item_t item);
      slid_pkg::out_item_t                res;
      int unsigned                        pos;
      logic signed [slid_pkg::ValueW-1:0] v;
      v   = item.operand_value;
      pos = 0;
      if (item.action == slid_pkg::ACT_INSERT) begin
        if (stored_q.size() >= Capacity) begin
          res.status = slid_pkg::ST_FULL;
        end else begin
          // a new value goes after every entry less than or equal to it
          while (pos < stored_q.size() && stored_q[pos] <= v) pos++;
          stored_q.insert(pos, v);
          res.status = slid_pkg::ST_INSERTED;
        end
      end else begin
        if (stored_q.size() == 0) begin
          res.status = slid_pkg::ST_EMPTY;
        end else begin
          while (pos < stored_q.size() && stored_q[pos] < v) pos++;
          if (pos < stored_q.size() && stored_q[pos] == v) begin
            stored_q.delete(pos);
            res.status = slid_pkg::ST_DELETED;
          end else begin
            res.status = slid_pkg::ST_NOMATCH;
          end
        end
      end
      res.entry_count = slid_pkg::CountW'(stored_q.size());
      expected_q.push_back(res);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(slid_pkg::out_item_t got);
      slid_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d count %0d",
                 $time, got.status, got.entry_count);
        fails++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
        fails++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count mismatch: expected %0d actual %0d",
                 $time, want.entry_count, got.entry_count);
        fails++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  slid_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  slid_pkg::out_item_t out_data_o;

  sorted_table_board sb = new;

  // Shared controls: idling on or off for both sides, and a request for the
  // receiver to hold off for a long stretch.
  bit          idle_en = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  sorted_list_insert_delete #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offer one transfer, idling beforehand at random, and note it in the
  // predictor at the edge that accepts it. Valid is only ever assigned once
  // per edge: either lowered for an idle cycle or raised with the new item.
  task automatic send_item(input slid_pkg::in_item_t item);
    while (idle_en && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(item);
  endtask

  task automatic send_op(input slid_pkg::action_e act,
                         input logic signed [slid_pkg::ValueW-1:0] v);
    slid_pkg::in_item_t item;
    item.action        = act;
    item.operand_value = v;
    send_item(item);
  endtask

  // Mix of extremes, a narrow band that breeds duplicates, and full-range noise.
  function automatic logic signed [slid_pkg::ValueW-1:0] pick_value();
    logic signed [slid_pkg::ValueW-1:0] v;
    case ($urandom_range(9))
      0:       v = {1'b1, {(slid_pkg::ValueW-1){1'b0}}};
      1:       v = {1'b0, {(slid_pkg::ValueW-1){1'b1}}};
      2, 3, 4: begin
        v = $urandom_range(15);
        v = v - 8;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Keys mostly hit a stored entry; the rest land beside one or anywhere.
  function automatic logic signed [slid_pkg::ValueW-1:0] pick_key();
    int unsigned roll;
    logic signed [slid_pkg::ValueW-1:0] k;
    roll = $urandom_range(99);
    if (sb.count() == 0 || roll >= 85) return pick_value();
    k = sb.entry_at($urandom_range(sb.count() - 1));
    if (roll >= 75) k = k + 1;
    return k;
  endfunction

  task automatic run_directed();
    send_op(slid_pkg::ACT_DELETE, 0);              // delete from an empty table
    send_op(slid_pkg::ACT_INSERT, 0);              // insert into an empty table
    send_op(slid_pkg::ACT_INSERT, {1'b1, {(slid_pkg::ValueW-1){1'b0}}});
    send_op(slid_pkg::ACT_INSERT, {1'b0, {(slid_pkg::ValueW-1){1'b1}}});
    send_op(slid_pkg::ACT_INSERT, -1);
    send_op(slid_pkg::ACT_INSERT, 0);              // duplicate goes after its twin
    send_op(slid_pkg::ACT_DELETE, 5);              // no equal entry
    send_op(slid_pkg::ACT_DELETE, 0);
    // remove the head, then the tail
    send_op(slid_pkg::ACT_DELETE, {1'b1, {(slid_pkg::ValueW-1){1'b0}}});
    send_op(slid_pkg::ACT_DELETE, {1'b0, {(slid_pkg::ValueW-1){1'b1}}});
    // fill up, then knock on the full table
    while (sb.count() < Capacity) send_op(slid_pkg::ACT_INSERT, pick_value());
    send_op(slid_pkg::ACT_INSERT, 3);
    send_op(slid_pkg::ACT_DELETE, pick_key());
    send_op(slid_pkg::ACT_INSERT, {1'b1, {(slid_pkg::ValueW-1){1'b0}}});
    send_op(slid_pkg::ACT_INSERT, -7);
  endtask

  // Alternate fill and drain phases so the table swings between full and empty.
  task automatic run_random();
    bit filling;
    filling = 1'b0;
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == 100) hold_request = 1'b1;
      if (n == 200) idle_en = 1'b0;
      if (n == 350) idle_en = 1'b1;
      if (n == 450) begin
        // pause the sender until every result is back
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      if (filling && sb.count() == Capacity && $urandom_range(99) < 30) filling = 1'b0;
      if (!filling && sb.count() == 0 && $urandom_range(99) < 30) filling = 1'b1;
      if ($urandom_range(99) < (filling ? 75 : 25))
        send_op(slid_pkg::ACT_INSERT, pick_value());
      else
        send_op(slid_pkg::ACT_DELETE, pick_key());
    end
  endtask

  // Receiver: check each transfer out, idle at random, and hold off for a
  // long stretch on request so the result register backs up into the input.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(idle_en && $urandom_range(99) < 13);
      end
    end
  end

  // Watchdog: end the run if no transfer moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_valid_i <= 1'b0;
    // drain, then wait for any stray result to show up
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
